// ===== design/xlps_pkg.sv =====
// ----------------------------------------------------------------------------
// xlps_pkg
// Shared constants and types for the cross-correlation lag peak search.
// ----------------------------------------------------------------------------
package xlps_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int LAG_W           = 12;
   localparam int PEAK_W          = 44;
   localparam int STATUS_W        = 2;
   localparam int MAX_LAG_W       = 12;
   localparam int MAX_LEN_DEFAULT = 4096;

   localparam logic [MAX_LAG_W-1:0] MAX_LAG_RESET = 12'd500;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   // control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic issue;
      logic first;
      logic last;
   } mac_ctrl_type;

   // tag that travels with a product down the pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_tag_type;

endpackage

// ===== design/xlps_ram.sv =====
// ----------------------------------------------------------------------------
// xlps_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module xlps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/xlps_mac.sv =====
// ----------------------------------------------------------------------------
// xlps_mac
// Shared multiply-accumulate unit: one product per cycle, per-lag sums and
// tracking of the first strict maximum with its lag.
// ----------------------------------------------------------------------------
module xlps_mac
   import xlps_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT,
   localparam int CNT_W  = $clog2(MAX_LEN + 1),
   localparam int ACC_W  = 2 * SAMPLE_W + CNT_W
) (
   input  logic                clock,
   input  logic                reset,
   input  mac_ctrl_type        ctrl,
   input  logic [SAMPLE_W-1:0] ref_data,
   input  logic [SAMPLE_W-1:0] probe_data,
   output logic                busy,
   output logic [ACC_W-1:0]    best_sum,
   output logic [CNT_W-1:0]    best_lag
);

   localparam int PROD_W = 2 * SAMPLE_W;

   mac_tag_type       tag1_ff, tag1_in;
   mac_tag_type       tag2_ff, tag2_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              done_ff, done_in;
   logic [ACC_W-1:0]  best_sum_ff, best_sum_in;
   logic [CNT_W-1:0]  best_lag_ff, best_lag_in;
   logic [CNT_W-1:0]  lag_cnt_ff, lag_cnt_in;

   always_comb begin
      tag1_in     = '{valid: ctrl.issue, first: ctrl.first, last: ctrl.last};
      tag2_in     = tag1_ff;
      prod_in     = ref_data * probe_data;
      acc_in      = acc_ff;
      done_in     = tag2_ff.valid & tag2_ff.last;
      best_sum_in = best_sum_ff;
      best_lag_in = best_lag_ff;
      lag_cnt_in  = lag_cnt_ff;

      if (tag2_ff.valid) begin
         if (tag2_ff.first) begin
            acc_in = ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end

      // lag sum complete: keep only a strictly larger one
      if (done_ff) begin
         if (acc_ff > best_sum_ff) begin
            best_sum_in = acc_ff;
            best_lag_in = lag_cnt_ff;
         end
         lag_cnt_in = lag_cnt_ff + CNT_W'(1);
      end

      if (ctrl.clear) begin
         tag1_in     = '0;
         tag2_in     = '0;
         done_in     = 1'b0;
         best_sum_in = '0;
         best_lag_in = '0;
         lag_cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff     <= '0;
         tag2_ff     <= '0;
         done_ff     <= 1'b0;
         best_sum_ff <= '0;
         best_lag_ff <= '0;
         lag_cnt_ff  <= '0;
      end else begin
         tag1_ff     <= tag1_in;
         tag2_ff     <= tag2_in;
         done_ff     <= done_in;
         best_sum_ff <= best_sum_in;
         best_lag_ff <= best_lag_in;
         lag_cnt_ff  <= lag_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign busy     = tag1_ff.valid | tag2_ff.valid | done_ff;
   assign best_sum = best_sum_ff;
   assign best_lag = best_lag_ff;

endmodule

// ===== design/xcorr_lag_peak_search_core.sv =====
// ----------------------------------------------------------------------------
// xcorr_lag_peak_search_core
// Loads reference/probe sample pairs, then slides the probe window against a
// centred reference window and reports the lag of the correlation peak.
//
//   channel   ports                               direction  handshake
//   request   req_ref_sample, req_probe_sample,   in         start & !busy
//             req_last
//   result    rsp_lag_steps, rsp_peak, rsp_status out        rsp_valid strobe
//   csr       csr_wr_data (max_lag)               in         csr_wr_en
//
// A request without last is stored in the two sample memories while room
// remains. After the last request of a set of N pairs the sequencer runs
// the single multiplier once per product, (N-M+1)*M products with window M,
// through check, setup, run, pipeline drain and result states; busy is high
// then. A too-short span goes from check straight to result. Synchronous
// reset clears the control state; memory contents stay undefined. The
// result strobe lasts one cycle and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module xcorr_lag_peak_search_core
   import xlps_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [SAMPLE_W-1:0]        req_ref_sample,
   input  logic [SAMPLE_W-1:0]        req_probe_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   output logic signed [LAG_W-1:0]    rsp_lag_steps,
   output logic [PEAK_W-1:0]          rsp_peak,
   output logic [STATUS_W-1:0]        rsp_status,
   input  logic                       csr_wr_en,
   input  logic [MAX_LAG_W-1:0]       csr_wr_data
);

   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ACC_W  = 2 * SAMPLE_W + CNT_W;
   localparam int CMP_W  = ((CNT_W > MAX_LAG_W + 1) ? CNT_W : MAX_LAG_W + 1) + 1;
   localparam int DIFF_W = (CNT_W > LAG_W) ? CNT_W : LAG_W;
   localparam int WIDE_W = (ACC_W > PEAK_W) ? ACC_W : PEAK_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SETUP,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [MAX_LAG_W-1:0]    max_lag_ff, max_lag_in;
   logic [CNT_W-1:0]        m_ff, m_in;
   logic [CNT_W-1:0]        span_ff, span_in;
   logic [CNT_W-1:0]        center_ff, center_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic [CNT_W-1:0]        j_ff, j_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LAG_W-1:0]        lag_ff, lag_in;
   logic [PEAK_W-1:0]       peak_ff, peak_in;

   logic                    accept;
   logic                    has_room;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [CNT_W-1:0]        ref_sum;
   logic [CNT_W-1:0]        probe_sum;
   logic [SAMPLE_W-1:0]     ref_data;
   logic [SAMPLE_W-1:0]     probe_data;
   mac_ctrl_type            mac_ctrl;
   logic                    mac_busy;
   logic [ACC_W-1:0]        best_sum;
   logic [CNT_W-1:0]        best_lag;

   logic                    too_short;
   logic [CNT_W-1:0]        half;
   logic signed [CMP_W-1:0] alt;
   logic [DIFF_W-1:0]       lag_diff;
   logic [WIDE_W-1:0]       best_wide;

   assign accept   = start & (state_ff == ST_IDLE);
   assign has_room = count_ff < CNT_W'(MAX_LEN);
   assign wr_en    = accept & has_room;
   assign wr_addr  = count_ff[ADDR_W-1:0];
   assign ref_sum  = center_ff + j_ff;
   assign probe_sum = i_ff + j_ff;

   assign too_short = (n_ff < CNT_W'(2)) || (CMP_W'(n_ff) <= CMP_W'(max_lag_ff));
   assign half      = n_ff >> 1;
   assign alt       = signed'(CMP_W'(n_ff)) - signed'(CMP_W'({max_lag_ff, 1'b0}));
   assign lag_diff  = DIFF_W'(best_lag) - DIFF_W'(center_ff);
   assign best_wide = WIDE_W'(best_sum);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      max_lag_in   = max_lag_ff;
      m_in         = m_ff;
      span_in      = span_ff;
      center_in    = center_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      lag_in       = lag_ff;
      peak_in      = peak_ff;
      mac_ctrl     = '0;

      if (csr_wr_en) begin
         max_lag_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  n_in     = has_room ? count_ff + CNT_W'(1) : count_ff;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            mac_ctrl.clear = 1'b1;
            if (too_short) begin
               status_in = STATUS_SHORT;
               state_in  = ST_FINISH;
            end else begin
               status_in = ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
               m_in      = (alt > signed'(CMP_W'(half))) ? alt[CNT_W-1:0] : half;
               state_in  = ST_SETUP;
            end
         end
         ST_SETUP: begin
            span_in   = n_ff - m_ff;
            center_in = (n_ff - m_ff) >> 1;
            i_in      = '0;
            j_in      = '0;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            mac_ctrl.issue = 1'b1;
            mac_ctrl.first = (j_ff == '0);
            mac_ctrl.last  = (j_ff == m_ff - CNT_W'(1));
            if (mac_ctrl.last) begin
               j_in = '0;
               if (i_ff == span_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + CNT_W'(1);
               end
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            if (status_ff == STATUS_SHORT || best_sum == '0) begin
               lag_in = '0;
            end else begin
               lag_in = lag_diff[LAG_W-1:0];
            end
            if (status_ff == STATUS_SHORT) begin
               peak_in = '0;
            end else if (best_wide > WIDE_W'({PEAK_W{1'b1}})) begin
               peak_in = {PEAK_W{1'b1}};
            end else begin
               peak_in = best_wide[PEAK_W-1:0];
            end
            count_in = '0;
            ovf_in   = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         max_lag_ff   <= MAX_LAG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         max_lag_ff   <= max_lag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff      <= n_in;
      m_ff      <= m_in;
      span_ff   <= span_in;
      center_ff <= center_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      status_ff <= status_in;
      lag_ff    <= lag_in;
      peak_ff   <= peak_in;
   end

   xlps_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LEN)
   ) u_ref_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ref_sample),
      .rd_en   (mac_ctrl.issue),
      .rd_addr (ref_sum[ADDR_W-1:0]),
      .rd_data (ref_data)
   );

   xlps_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LEN)
   ) u_probe_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_probe_sample),
      .rd_en   (mac_ctrl.issue),
      .rd_addr (probe_sum[ADDR_W-1:0]),
      .rd_data (probe_data)
   );

   xlps_mac #(
      .MAX_LEN (MAX_LEN)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .ref_data   (ref_data),
      .probe_data (probe_data),
      .busy       (mac_busy),
      .best_sum   (best_sum),
      .best_lag   (best_lag)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lag_steps = signed'(lag_ff);
   assign rsp_peak      = peak_ff;
   assign rsp_status    = status_ff;

endmodule
